/* src/srs_pkg.sv */
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the stochastic reaction step
// Operation codes, config indexes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int SPECIES    = 4;
    localparam int REACTIONS  = 4;
    localparam int COUNT_BITS = 16;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_STEP_UPD = 2'd1;
    localparam logic [1:0] OP_STEP     = 2'd2;
    localparam logic [1:0] OP_STEP_ALT = 2'd3;

    localparam logic [1:0] ORD_LINEAR = 2'd1;
    localparam logic [1:0] ORD_SQUARE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_CLAMPED = 2'd2;

    localparam logic [2:0] CFG_ORDER  = 3'd0;
    localparam logic [2:0] CFG_CHANGE = 3'd1;
    localparam logic [2:0] CFG_RATE0  = 3'd2;
    localparam logic [2:0] CFG_RATE3  = 3'd5;
    localparam logic [2:0] CFG_START  = 3'd6;

    typedef struct packed {
        logic load;
        logic prop_init;
        logic prop_mul;
        logic prop_mul_hi;
        logic prop_done;
        logic t_lo;
        logic t_hi;
        logic choose;
        logic log_init;
        logic log_sq;
        logic log_fin;
        logic log_mul;
        logic div_init;
        logic div_step;
        logic update;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_start;
    } t_sts;

endpackage

/* src/srs_datapath.sv */
// ----------------------------------------------------------------------------
// srs_datapath: registers and arithmetic for one reaction step
// Shared 32x32 multiplier, iterative log squaring, radix-2 divider.
// ----------------------------------------------------------------------------
module srs_datapath
    import srs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic [1:0]           i_operation,
    input  logic [31:0]          i_choice_random,
    input  logic [31:0]          i_time_random,
    input  srs_pkg::t_cmd        i_cmd,
    input  logic [1:0]           i_rsel,
    input  logic [1:0]           i_ssel,
    output srs_pkg::t_sts        o_sts,
    output logic [1:0]           o_reaction,
    output logic [63:0]          o_wait_time,
    output logic [63:0]          o_total_rate,
    output logic [15:0]          o_count_a,
    output logic [15:0]          o_count_b,
    output logic [15:0]          o_count_c,
    output logic [15:0]          o_count_d,
    output logic [1:0]           o_status
);
    logic [31:0] r_order;
    logic [63:0] r_change;
    logic [31:0] r_rate [REACTIONS];
    logic [63:0] r_startc;
    logic [COUNT_BITS-1:0] r_cnt [SPECIES];
    logic [31:0] r_sq [SPECIES];

    logic [1:0]  r_op;
    logic [31:0] r_u1;
    logic [32:0] r_m;
    logic [63:0] r_part [REACTIONS];
    logic [63:0] r_p;
    logic [63:0] r_total;
    logic [63:0] r_tlo;
    logic [95:0] r_t;
    logic [1:0]  r_chosen;
    logic [32:0] r_x;
    logic [31:0] r_frac;
    logic [5:0]  r_e;
    logic [63:0] r_ln;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [79:0] r_num;
    logic [1:0]  r_status;

    // cfg
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order  <= '0;
            r_change <= '0;
            r_startc <= '0;
            for (int k = 0; k < REACTIONS; k++) r_rate[k] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORDER:  r_order  <= i_cfg_data[31:0];
                CFG_CHANGE: r_change <= i_cfg_data;
                CFG_START:  r_startc <= i_cfg_data;
                default: begin
                    if (i_cfg_index >= CFG_RATE0 && i_cfg_index <= CFG_RATE3)
                        r_rate[2'(i_cfg_index - CFG_RATE0)] <= i_cfg_data[31:0];
                end
            endcase
        end
    end

    // squared counts, registered from the counts
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SPECIES; k++)
            r_sq[k] <= 32'(r_cnt[k]) * 32'(r_cnt[k]);
    end

    // ln: l2 = 32 - (e.frac) in Q.32
    logic [63:0] w_l2;
    assign w_l2 = {26'd0, 6'd32 - r_e, 32'd0} - {32'd0, r_frac};

    // propensity multiply: 64-bit p by value v (<=32 bits) in two halves
    logic [1:0]  w_ord;
    logic [15:0] w_n;
    logic [31:0] w_v;
    logic [63:0] w_prod;
    logic [31:0] w_ma, w_mb;
    assign w_ord = r_order[{i_rsel, i_ssel, 1'b0} +: 2];
    assign w_n   = 16'(r_cnt[i_ssel]);
    assign w_v   = (w_ord == ORD_LINEAR) ? {16'd0, w_n} : r_sq[i_ssel];

    // log squaring and ln multiply share this multiplier
    always_comb begin
        if (i_cmd.log_sq) begin
            w_ma = r_x[31:0];
            w_mb = r_x[31:0];
        end else if (i_cmd.log_mul) begin
            w_ma = w_l2[31:0];
            w_mb = LN2_Q32;
        end else begin
            w_ma = i_cmd.prop_mul_hi ? r_p[63:32] : r_p[31:0];
            w_mb = w_v;
        end
    end
    assign w_prod = 64'(w_ma) * 64'(w_mb);

    // square of 33-bit x where x in [2^31,2^32): top bit of r_x unused here
    logic [63:0] w_sq;
    assign w_sq = w_prod >> 31;

    logic [96:0] w_fullp;
    assign w_fullp = ({33'd0, w_prod} << 32) + {33'd0, r_num[63:0]};

    logic [63:0] w_mulres;
    always_comb begin
        if (w_ord == ORD_LINEAR)
            w_mulres = (w_fullp[96:64] != '0) ? '1 : w_fullp[63:0];
        else
            w_mulres = (w_fullp[96:65] != '0) ? '1 : w_fullp[64:1];
    end

    logic [64:0] w_tsum;
    logic [63:0] w_tnext;
    assign w_tsum  = {1'b0, r_total} + {1'b0, r_p};
    assign w_tnext = w_tsum[64] ? '1 : w_tsum[63:0];

    // choice: t = u1*total in two halves, compare with partial<<32
    logic [31:0] w_cmb;
    logic [63:0] w_cprod;
    assign w_cmb   = i_cmd.t_hi ? r_total[63:32] : r_total[31:0];
    assign w_cprod = 64'(r_u1) * 64'(w_cmb);

    logic [1:0] w_pick;
    always_comb begin
        logic [63:0] prev;
        logic        found;
        prev   = '0;
        found  = 1'b0;
        w_pick = 2'd0;
        for (int k = 0; k < REACTIONS; k++) begin
            if (!found && ({prev, 32'd0} < r_t) && !({r_part[k], 32'd0} < r_t)) begin
                found  = 1'b1;
                w_pick = 2'(k);
            end
            prev = r_part[k];
        end
    end

    // leading one of m
    logic [5:0] w_e;
    always_comb begin
        w_e = 6'd0;
        for (int k = 1; k <= 32; k++)
            if (r_m[k]) w_e = 6'(k);
    end

    // divider step
    logic [64:0] w_rs;
    logic        w_ge;
    assign w_rs = {r_rem, r_num[79]};
    assign w_ge = w_rs >= {1'b0, r_total};

    // update
    logic [COUNT_BITS-1:0] w_upd [SPECIES];
    logic                  w_clamp;
    always_comb begin
        logic signed [3:0]  dec;
        logic signed [18:0] v;
        w_clamp = 1'b0;
        for (int k = 0; k < SPECIES; k++) begin
            dec = $signed(r_change[{r_chosen, 2'(k), 2'b00} +: 4]);
            v   = $signed({3'd0, r_cnt[k]}) - 19'(dec);
            if (v < 0) begin
                w_upd[k] = '0;
                w_clamp  = 1'b1;
            end else if (v > 19'((1 << COUNT_BITS) - 1)) begin
                w_upd[k] = '1;
                w_clamp  = 1'b1;
            end else begin
                w_upd[k] = v[COUNT_BITS-1:0];
            end
        end
    end

    logic [63:0] w_lnprod;
    assign w_lnprod = 64'(w_l2[37:32]) * 64'(LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SPECIES; k++) r_cnt[k] <= '0;
        end else begin
            if (i_cmd.load && i_operation == OP_START)
                for (int k = 0; k < SPECIES; k++)
                    r_cnt[k] <= r_startc[16*k +: COUNT_BITS];
            if (i_cmd.update && r_op == OP_STEP_UPD && r_total != '0)
                for (int k = 0; k < SPECIES; k++) r_cnt[k] <= w_upd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_u1    <= i_choice_random;
            r_m     <= 33'(i_time_random) + 33'd1;
            r_total <= '0;
            r_status <= ST_OK;
            r_chosen <= '0;
        end
        if (i_cmd.prop_init) begin
            r_p <= 64'(r_rate[i_rsel]);
        end
        if (i_cmd.prop_mul && !i_cmd.prop_mul_hi) begin
            r_num[63:0] <= w_prod;
        end
        if (i_cmd.prop_mul && i_cmd.prop_mul_hi) begin
            if (w_ord == ORD_LINEAR || w_ord == ORD_SQUARE) r_p <= w_mulres;
        end
        if (i_cmd.prop_done) begin
            r_part[i_rsel] <= w_tnext;
            r_total <= w_tnext;
        end
        if (i_cmd.t_lo) begin
            r_tlo <= w_cprod;
        end
        if (i_cmd.t_hi) begin
            r_t <= {w_cprod, 32'd0} + {32'd0, r_tlo};
        end
        if (i_cmd.choose) begin
            r_chosen <= w_pick;
        end
        if (i_cmd.log_init) begin
            r_e    <= w_e;
            r_x    <= (w_e <= 6'd31) ? 33'(r_m << (6'd31 - w_e)) : (r_m >> 1);
            r_frac <= '0;
        end
        if (i_cmd.log_sq) begin
            if (w_sq[32]) begin
                r_x    <= 33'(w_sq[32:1]);
                r_frac <= {r_frac[30:0], 1'b1};
            end else begin
                r_x    <= w_sq[32:0];
                r_frac <= {r_frac[30:0], 1'b0};
            end
        end
        if (i_cmd.log_mul) begin
            // low part first
            r_num[63:0] <= w_prod;
        end
        if (i_cmd.log_fin) begin
            r_ln <= w_lnprod + {32'd0, r_num[63:32]} + 64'(r_num[31]);
        end
        if (i_cmd.div_init) begin
            r_num <= {r_ln, 16'd0};
            r_rem <= '0;
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[78:0], 1'b0};
            r_rem <= w_ge ? 64'(w_rs - {1'b0, r_total}) : w_rs[63:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
        if (i_cmd.update && r_op != OP_START && r_total != '0 && r_op == OP_STEP_UPD
            && w_clamp)
            r_status <= ST_CLAMPED;
        if (i_cmd.update && r_op != OP_START && r_total == '0)
            r_status <= ST_ZERO;
        if (i_cmd.finish) begin
            o_reaction   <= (r_op == OP_START || r_total == '0) ? 2'd0 : r_chosen;
            o_wait_time  <= (r_op == OP_START) ? 64'd0 : (r_total == '0) ? '1 : r_quo;
            o_total_rate <= (r_op == OP_START) ? 64'd0 : r_total;
            o_status     <= r_status;
            o_count_a    <= 16'(r_cnt[0]);
            o_count_b    <= 16'(r_cnt[1]);
            o_count_c    <= 16'(r_cnt[2]);
            o_count_d    <= 16'(r_cnt[3]);
        end
    end

    assign o_sts.is_start = (r_op == OP_START);
endmodule

/* src/srs_ctrl.sv */
// ----------------------------------------------------------------------------
// srs_ctrl: sequencer for one reaction step
// Walks propensities, choice, logarithm, division, update and output.
// ----------------------------------------------------------------------------
module srs_ctrl
    import srs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  srs_pkg::t_sts i_sts,
    output srs_pkg::t_cmd o_cmd,
    output logic [1:0]    o_rsel,
    output logic [1:0]    o_ssel
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PINIT = 11'b00000000010,
        S_MLO   = 11'b00000000100,
        S_MHI   = 11'b00000001000,
        S_PDONE = 11'b00000010000,
        S_LOG   = 11'b00000100000,
        S_LMUL  = 11'b00001000000,
        S_LFIN  = 11'b00010000000,
        S_DIV   = 11'b00100000000,
        S_UPD   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_r, n_r, r_s, n_s;
    logic [6:0] r_k, n_k;
    logic       r_ov, n_ov;

    assign o_rsel      = r_r;
    assign o_ssel      = r_s;
    assign o_out_valid = r_ov;
    assign o_in_stall  = (r_state != S_IDLE) || (r_ov && i_out_stall);

    always_comb begin
        n_state = r_state;
        n_r = r_r;
        n_s = r_s;
        n_k = r_k;
        n_ov = (r_ov && i_out_stall);
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.load = 1'b1;
                    n_r = '0;
                    n_s = '0;
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                if (i_sts.is_start) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.prop_init = 1'b1;
                    n_s = '0;
                    n_state = S_MLO;
                end
            end
            S_MLO: begin
                o_cmd.prop_mul = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.prop_mul = 1'b1;
                o_cmd.prop_mul_hi = 1'b1;
                if (r_s == 2'(SPECIES - 1)) n_state = S_PDONE;
                else begin
                    n_s = r_s + 2'd1;
                    n_state = S_MLO;
                end
            end
            S_PDONE: begin
                o_cmd.prop_done = 1'b1;
                if (r_r == 2'(REACTIONS - 1)) begin
                    o_cmd.log_init = 1'b1;
                    n_k = '0;
                    n_state = S_LOG;
                end else begin
                    n_r = r_r + 2'd1;
                    n_state = S_PINIT;
                end
            end
            S_LOG: begin
                o_cmd.log_sq = 1'b1;
                if (r_k == 7'd0) o_cmd.t_lo = 1'b1;
                if (r_k == 7'd1) o_cmd.t_hi = 1'b1;
                if (r_k == 7'd2) o_cmd.choose = 1'b1;
                n_k = r_k + 7'd1;
                if (r_k == 7'd31) n_state = S_LMUL;
            end
            S_LMUL: begin
                o_cmd.log_mul = 1'b1;
                n_state = S_LFIN;
            end
            S_LFIN: begin
                o_cmd.log_fin = 1'b1;
                n_k = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_k == 7'd0) o_cmd.div_init = 1'b1;
                else o_cmd.div_step = 1'b1;
                n_k = r_k + 7'd1;
                if (r_k == 7'd80) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!(r_ov && i_out_stall)) begin
                    o_cmd.finish = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r <= '0;
            r_s <= '0;
            r_k <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_r <= n_r;
            r_s <= n_s;
            r_k <= n_k;
            r_ov <= n_ov;
        end
    end
endmodule

/* src/stochastic_reaction_step.sv */
// ----------------------------------------------------------------------------
// stochastic_reaction_step: one direct-method stochastic simulation step
//
// channel | direction | handshake           | word
// in      | input     | i_in_valid/o_in_stall | operation, two random words
// out     | output    | o_out_valid/i_out_stall | reaction, times, counts
// cfg     | input     | i_cfg_valid/o_cfg_ready | index, data
//
// A step word runs in order: per reaction a rate load, two multiplier passes
// per species and a sum; then the log squaring steps, ln scaling, the
// radix-2 divider, the count update and the output register. A start word
// goes straight to the update and output register. Reset is synchronous;
// counts clear to zero. The next word is taken only once the result has
// been registered; a stalled result blocks the next word.
// ----------------------------------------------------------------------------
module stochastic_reaction_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_choice_random,
    input  logic [31:0] i_time_random,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_reaction,
    output logic [63:0] o_wait_time,
    output logic [63:0] o_total_rate,
    output logic [15:0] o_count_a,
    output logic [15:0] o_count_b,
    output logic [15:0] o_count_c,
    output logic [15:0] o_count_d,
    output logic [1:0]  o_status
);
    import srs_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [1:0] w_rsel, w_ssel;

    assign o_cfg_ready = 1'b1;

    srs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .i_sts(w_sts), .o_cmd(w_cmd), .o_rsel(w_rsel), .o_ssel(w_ssel)
    );

    srs_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_operation, .i_choice_random, .i_time_random,
        .i_cmd(w_cmd), .i_rsel(w_rsel), .i_ssel(w_ssel), .o_sts(w_sts),
        .o_reaction, .o_wait_time, .o_total_rate,
        .o_count_a, .o_count_b, .o_count_c, .o_count_d, .o_status
    );
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for stochastic_reaction_step
// Drives start and step words with random idling on both channels, predicts
// each result with a local fixed-point model of the step and compares every
// output field in order. Several register settings are used, extremes too.
// ----------------------------------------------------------------------------
module tb_top;
    import srs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [31:0] choice_rnd = '0;
    logic [31:0] time_rnd = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  reaction;
    logic [63:0] wait_time, total_rate;
    logic [15:0] count_a, count_b, count_c, count_d;
    logic [1:0]  status;

    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;

    typedef struct packed {
        logic [1:0]  reaction;
        logic [63:0] wait_time;
        logic [63:0] total_rate;
        logic [15:0] cnt_a, cnt_b, cnt_c, cnt_d;
        logic [1:0]  status;
    } t_step_result;

    always #5 clk = ~clk;

    stochastic_reaction_step u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_operation(operation), .i_choice_random(choice_rnd),
        .i_time_random(time_rnd),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_reaction(reaction), .o_wait_time(wait_time), .o_total_rate(total_rate),
        .o_count_a(count_a), .o_count_b(count_b), .o_count_c(count_c),
        .o_count_d(count_d), .o_status(status)
    );

    class step_scoreboard;
        logic [31:0]  orders;
        logic [63:0]  changes;
        logic [31:0]  rate_k [4];
        logic [63:0]  init_counts;
        logic [15:0]  counts [4];
        t_step_result pending [$];
        int           errors;

        function new();
            orders = '0;
            changes = '0;
            init_counts = '0;
            errors = 0;
            for (int i = 0; i < 4; i++) begin
                rate_k[i] = '0;
                counts[i] = '0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            if (idx == CFG_ORDER) orders = val[31:0];
            else if (idx == CFG_CHANGE) changes = val;
            else if (idx >= CFG_RATE0 && idx <= CFG_RATE3) rate_k[idx - CFG_RATE0] = val[31:0];
            else if (idx == CFG_START) init_counts = val;
        endfunction

        function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        endfunction

        function logic [63:0] ln_q32(logic [32:0] m);
            int          e;
            logic [63:0] x, frac, l2;
            logic [127:0] p;
            e = 0;
            frac = '0;
            while (e < 32 && (m >> (e + 1)) != 0) e++;
            x = (e <= 31) ? (64'(m) << (31 - e)) : 64'(m >> 1);
            for (int i = 0; i < 32; i++) begin
                x = (x * x) >> 31;
                frac = frac << 1;
                if (x >= 64'h1_0000_0000) begin
                    x = x >> 1;
                    frac[0] = 1'b1;
                end
            end
            l2 = (64'd32 << 32) - ((64'(e) << 32) | frac);
            p = 128'(l2) * 128'(LN2_Q32) + (128'd1 << 31);
            return p[95:32];
        endfunction

        function void note_word(logic [1:0] op, logic [31:0] u1, logic [31:0] u2);
            t_step_result  r;
            logic [63:0]   prop [4];
            logic [63:0]   total, prev, part, p;
            logic [127:0]  w, t;
            logic [1:0]    ord;
            logic [3:0]    raw;
            int            v;
            logic [1:0]    pick;
            bit            found;
            r = '0;
            total = '0;
            if (op == OP_START) begin
                for (int s = 0; s < 4; s++) counts[s] = init_counts[16*s +: 16];
            end else begin
                for (int k = 0; k < 4; k++) begin
                    p = 64'(rate_k[k]);
                    for (int s = 0; s < 4; s++) begin
                        ord = orders[2*(4*k+s) +: 2];
                        if (ord == ORD_LINEAR) begin
                            w = 128'(p) * 128'(counts[s]);
                            p = (w[127:64] != 0) ? '1 : w[63:0];
                        end else if (ord == ORD_SQUARE) begin
                            w = 128'(p) * 128'(64'(counts[s]) * 64'(counts[s]));
                            p = (w[127:65] != 0) ? '1 : w[64:1];
                        end
                    end
                    prop[k] = p;
                    total = sat_add(total, p);
                end
                r.total_rate = total;
                if (total == 0) begin
                    r.status = ST_ZERO;
                    r.wait_time = '1;
                end else begin
                    t = 128'(u1) * 128'(total);
                    prev = '0;
                    pick = '0;
                    found = 0;
                    for (int k = 0; k < 4; k++) begin
                        part = sat_add(prev, prop[k]);
                        if (!found && ({prev, 32'd0} < t) && ({part, 32'd0} >= t)) begin
                            pick = k[1:0];
                            found = 1;
                        end
                        prev = part;
                    end
                    r.reaction = pick;
                    r.wait_time = (ln_q32(33'(u2) + 33'd1) << 16) / total;
                    if (op == OP_STEP_UPD) begin
                        for (int s = 0; s < 4; s++) begin
                            raw = changes[4*(4*pick+s) +: 4];
                            v = int'(counts[s]) - int'($signed(raw));
                            if (v < 0) begin
                                v = 0;
                                r.status = ST_CLAMPED;
                            end else if (v > 65535) begin
                                v = 65535;
                                r.status = ST_CLAMPED;
                            end
                            counts[s] = v[15:0];
                        end
                    end
                end
            end
            r.cnt_a = counts[0];
            r.cnt_b = counts[1];
            r.cnt_c = counts[2];
            r.cnt_d = counts[3];
            pending = {pending, r};
        endfunction

        function void check_result(t_step_result got);
            t_step_result exp;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.reaction !== exp.reaction)
                $display("%0t reaction exp %0d got %0d", $time, exp.reaction, got.reaction);
            if (got.wait_time !== exp.wait_time)
                $display("%0t wait_time exp %h got %h", $time, exp.wait_time, got.wait_time);
            if (got.total_rate !== exp.total_rate)
                $display("%0t total_rate exp %h got %h", $time, exp.total_rate, got.total_rate);
            if (got.cnt_a !== exp.cnt_a)
                $display("%0t count_a exp %0d got %0d", $time, exp.cnt_a, got.cnt_a);
            if (got.cnt_b !== exp.cnt_b)
                $display("%0t count_b exp %0d got %0d", $time, exp.cnt_b, got.cnt_b);
            if (got.cnt_c !== exp.cnt_c)
                $display("%0t count_c exp %0d got %0d", $time, exp.cnt_c, got.cnt_c);
            if (got.cnt_d !== exp.cnt_d)
                $display("%0t count_d exp %0d got %0d", $time, exp.cnt_d, got.cnt_d);
            if (got.status !== exp.status)
                $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
            if (got !== exp) errors++;
        endfunction
    endclass

    step_scoreboard sb = new();

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({reaction, wait_time, total_rate, count_a, count_b, count_c,
                             count_d, status});
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(logic [1:0] op, logic [31:0] u1, logic [31:0] u2);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        choice_rnd <= u1;
        time_rnd <= u2;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(op, u1, u2);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic load_setup(logic [31:0] ord, logic [63:0] chg, logic [31:0] rmask,
                              logic [63:0] init);
        drain();
        write_reg(CFG_ORDER, ord);
        write_reg(CFG_CHANGE, chg);
        for (int k = 0; k < 4; k++)
            write_reg(CFG_RATE0 + 3'(k), {$urandom(), $urandom()} & 64'(rmask));
        write_reg(CFG_START, init);
    endtask

    task automatic rand_setup();
        logic [63:0] init;
        logic [31:0] rmask;
        int mode;
        mode = $urandom_range(3);
        for (int s = 0; s < 4; s++)
            init[16*s +: 16] = (mode == 0) ? 16'($urandom) : 16'($urandom_range(40));
        rmask = (mode == 3) ? '1 : 32'h000F_FFFF;
        load_setup($urandom(), {$urandom(), $urandom()}, rmask, init);
        send_word(OP_START, $urandom(), $urandom());
    endtask

    task automatic rand_phase(int n);
        int op;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 59) rand_setup();
            op = $urandom_range(99);
            send_word(op < 5 ? OP_START : op < 75 ? OP_STEP_UPD : op < 95 ? OP_STEP : OP_STEP_ALT,
                      $urandom(), $urandom());
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // zero total straight after reset, then extremes
        send_word(OP_STEP_UPD, '1, '0);
        load_setup('1, '1, '1, '1);
        write_reg(CFG_ORDER, 32'h5555_5555);
        send_word(OP_START, '0, '0);
        send_word(OP_STEP_UPD, '1, '1);
        send_word(OP_STEP, '0, '0);
        send_word(OP_STEP_ALT, 32'h8000_0000, 32'h7FFF_FFFF);
        load_setup(32'hAAAA_AAAA, 64'h8888_8888_8888_8888, '1, 64'h0001_00FF_FFFF_0002);
        send_word(OP_START, '0, '0);
        for (int i = 0; i < 6; i++) send_word(OP_STEP_UPD, $urandom(), $urandom());
        load_setup(32'h0F0F_0F0F, 64'h7777_7777_7777_7777, 32'h0001_0000, 64'h0003_0002_0001_0000);
        send_word(OP_START, '0, '0);
        for (int i = 0; i < 8; i++) send_word(OP_STEP_UPD, $urandom(), $urandom());
        send_word(OP_STEP, '0, '1);
        send_word(OP_STEP, '1, 32'h0000_0001);
        drain();
        send_idle = 15;
        recv_idle = 46;
        rand_setup();
        rand_phase(600);
        drain();
        send_idle = 46;
        recv_idle = 15;
        rand_phase(600);
        drain();
        send_idle = 0;
        recv_idle = 0;
        rand_phase(620);
        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

/* files.f */
src/srs_pkg.sv
src/srs_datapath.sv
src/srs_ctrl.sv
src/stochastic_reaction_step.sv
sim/tb_top.sv
